### hdl/upd_pkg.sv
// Shared types, character constants and the hex digit helper of the percent decoder.
package upd_pkg;

  // Characters with a meaning of their own in the encoded stream.
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharSpace   = 8'h20;

  // Most decoded bytes that one raw byte can cause.
  localparam int unsigned MaxGroup = 3;

  // One raw byte of the encoded stream.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } upd_in_t;

  // One decoded byte.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       stream_end;
  } upd_out_t;

  // The decoded bytes caused by one raw byte, as the front end hands them on.
  typedef struct packed {
    logic [MaxGroup-1:0][7:0] data;
    logic [1:0]               count;
    logic                     last;
  } upd_grp_t;

  // Escape tracking: nothing pending, '%' seen, '%' and one byte seen.
  typedef enum logic [2:0] {
    PhIdle = 3'b001,
    PhPct  = 3'b010,
    PhHeld = 3'b100
  } upd_phase_e;

  // Value of a hex digit in the low four bits; bit four is set if the byte is no digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
        v = c - 8'd48;
      end else if (c >= 8'h41 && c <= 8'h46) begin
        v = c - 8'd55;
      end else if (c >= 8'h61 && c <= 8'h66) begin
        v = c - 8'd87;
      end
      return v[4:0];
    end
  endfunction

endpackage

### hdl/upd_front.sv
// Front end: takes raw bytes, tracks escapes and builds the group of decoded bytes.
module upd_front import upd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  upd_in_t  in_req_i,
  output logic     push_o,
  output upd_grp_t grp_o,
  input  logic     full_i
);

  upd_phase_e phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       accept;
  logic [7:0] b;
  logic       last;
  logic [4:0] hi_val;
  logic [4:0] lo_val;
  logic       plain_emit;
  logic [7:0] plain_byte;
  logic       plain_open;
  logic [1:0] n;

  assign b          = in_req_i.in_byte;
  assign last       = in_req_i.in_last;
  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign hi_val     = hex_value(held_q);
  assign lo_val     = hex_value(b);

  // Rules for a byte with no escape pending.
  always_comb begin
    plain_emit = 1'b1;
    plain_open = 1'b0;
    plain_byte = b;
    if (b == CharPercent) begin
      plain_emit = last;
      plain_open = !last;
    end else if (b == CharPlus) begin
      plain_byte = CharSpace;
    end
  end

  // Build the group of decoded bytes and the next escape state.
  always_comb begin
    grp_o   = '0;
    n       = 2'd0;
    phase_d = phase_q;
    held_d  = held_q;
    unique case (phase_q)
      PhPct: begin
        if (last) begin
          grp_o.data[n] = CharPercent;
          n = n + 2'd1;
          grp_o.data[n] = b;
          n = n + 2'd1;
          phase_d = PhIdle;
        end else begin
          held_d  = b;
          phase_d = PhHeld;
        end
      end
      PhHeld: begin
        if (!hi_val[4] && !lo_val[4]) begin
          grp_o.data[n] = {hi_val[3:0], lo_val[3:0]};
          n = n + 2'd1;
          phase_d = PhIdle;
        end else begin
          grp_o.data[n] = CharPercent;
          n = n + 2'd1;
          if (held_q == CharPercent) begin
            // The held byte opens a new escape, and this byte follows it.
            if (last) begin
              grp_o.data[n] = CharPercent;
              n = n + 2'd1;
              grp_o.data[n] = b;
              n = n + 2'd1;
              phase_d = PhIdle;
            end else begin
              held_d  = b;
              phase_d = PhHeld;
            end
          end else begin
            grp_o.data[n] = (held_q == CharPlus) ? CharSpace : held_q;
            n = n + 2'd1;
            if (plain_emit) begin
              grp_o.data[n] = plain_byte;
              n = n + 2'd1;
            end
            phase_d = plain_open ? PhPct : PhIdle;
          end
        end
      end
      default: begin
        if (plain_emit) begin
          grp_o.data[n] = plain_byte;
          n = n + 2'd1;
        end
        phase_d = plain_open ? PhPct : PhIdle;
      end
    endcase
    if (last) begin
      phase_d = PhIdle;
    end
    grp_o.count = n;
    grp_o.last  = last;
  end

  assign push_o = accept && (n != 2'd0);

  // Escape state advances on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

### hdl/upd_fifo.sv
// Short queue of decoded byte groups between the front and back ends.
module upd_fifo import upd_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  upd_grp_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output upd_grp_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  upd_grp_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hdl/upd_back.sv
// Back end: sends the bytes of each queued group out one at a time.
module upd_back import upd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  upd_grp_t grp_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output upd_out_t out_req_o
);

  logic       out_valid_q, out_valid_d;
  upd_out_t   out_q, out_d;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic       final_byte;

  assign load       = !out_valid_q || !out_stall_i;
  assign final_byte = (idx_q == grp_i.count - 2'd1);

  // Pick the next byte of the head group whenever the output register frees up.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = !empty_i;
      if (!empty_i) begin
        out_d.out_byte   = grp_i.data[idx_q];
        out_d.run_end    = final_byte;
        out_d.stream_end = final_byte && grp_i.last;
        if (final_byte) begin
          pop_o = 1'b1;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end
  end

  // Output register and position within the head group.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

### hdl/url_percent_decoder.sv
// Top level of the streaming URL percent decoder.
// The decoder takes one raw byte per cycle while its queue is not full, and sends out
// one decoded byte per cycle while the output is not stalled. A raw byte causes zero
// to three decoded bytes: a '+' becomes a space, a '%' and two hex digits become one
// byte, a '%' with a bad digit comes out literally and its two held bytes are decoded
// again, and a '%' cut short by the end of the stream comes out raw with the bytes
// after it. The front end classifies each byte in the cycle it is accepted and writes
// the group of its decoded bytes into a queue of FifoDepth entries; the back end reads
// one byte per cycle from the queue head into the output register while the output is
// not stalled. So each decoded byte passes through a queue entry and then the output
// register. The input stalls only while the queue is full, which happens when groups
// of two or three bytes arrive faster than the output drains them. run_end marks the
// last decoded byte of each raw byte, and stream_end marks the last one of the stream.
module url_percent_decoder import upd_pkg::*; #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  upd_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output upd_out_t out_req_o
);

  logic     push;
  logic     full;
  logic     pop;
  logic     empty;
  upd_grp_t grp_wr;
  upd_grp_t grp_rd;

  // Byte classification and escape tracking.
  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .push_o     (push),
    .grp_o      (grp_wr),
    .full_i     (full)
  );

  // Queue of decoded byte groups.
  upd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (grp_wr),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (grp_rd)
  );

  // Serialization onto the output channel.
  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .grp_i       (grp_rd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
